// ===== rtl/core/dbc_pkg.sv =====
`default_nettype none

package dbc_pkg;

    // Counter sizing; each counter is held to the narrower of its own
    // size and its result field.
    localparam int DEPTH_BITS  = 16;
    localparam int LINE_BITS   = 24;
    localparam int COLUMN_BITS = 16;

    localparam int COUNT_FIELD_W  = 16;
    localparam int LINE_FIELD_W   = 24;
    localparam int COLUMN_FIELD_W = 16;

    localparam int DEPTH_W  = (DEPTH_BITS  < COUNT_FIELD_W)  ? DEPTH_BITS  : COUNT_FIELD_W;
    localparam int LINE_W   = (LINE_BITS   < LINE_FIELD_W)   ? LINE_BITS   : LINE_FIELD_W;
    localparam int COLUMN_W = (COLUMN_BITS < COLUMN_FIELD_W) ? COLUMN_BITS : COLUMN_FIELD_W;

    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;

    typedef enum logic [1:0] {
        ST_VALID = 2'd0,
        ST_CLOSE = 2'd1,
        ST_OPEN  = 2'd2,
        ST_OVF   = 2'd3
    } status_t;

    typedef struct packed {
        logic [DEPTH_W-1:0]  brace;
        logic [DEPTH_W-1:0]  paren;
        logic [DEPTH_W-1:0]  bracket;
        logic [LINE_W-1:0]   line;
        logic [COLUMN_W-1:0] column;
        status_t             lat_status;
        logic [LINE_W-1:0]   lat_line;
        logic [COLUMN_W-1:0] lat_column;
    } scan_state_t;

    typedef struct packed {
        status_t                   status;
        logic [LINE_FIELD_W-1:0]   error_line;
        logic [COLUMN_FIELD_W-1:0] error_column;
        logic [COUNT_FIELD_W-1:0]  braces_left;
        logic [COUNT_FIELD_W-1:0]  parens_left;
        logic [COUNT_FIELD_W-1:0]  brackets_left;
    } result_t;

    localparam scan_state_t STATE_CLEAR = '{
        brace:      '0,
        paren:      '0,
        bracket:    '0,
        line:       LINE_W'(1),
        column:     COLUMN_W'(1),
        lat_status: ST_VALID,
        lat_line:   '0,
        lat_column: '0
    };

endpackage

`default_nettype wire

// ===== rtl/core/dbc_step.sv =====
`default_nettype none

module dbc_step import dbc_pkg::*;
(
    input  wire logic        enable,
    input  wire logic [7:0]  byte_in,
    input  wire scan_state_t cur,
    output scan_state_t      nxt,
    output result_t          res
);

    logic is_open;
    logic is_close;
    logic sel_brace;
    logic sel_paren;
    logic sel_bracket;
    logic [DEPTH_W-1:0] sel_depth;
    logic [DEPTH_W-1:0] new_depth;
    logic latched;

    always_comb
    begin
        sel_brace   = (byte_in == CH_LBRACE)   || (byte_in == CH_RBRACE);
        sel_paren   = (byte_in == CH_LPAREN)   || (byte_in == CH_RPAREN);
        sel_bracket = (byte_in == CH_LBRACKET) || (byte_in == CH_RBRACKET);
        is_open     = (byte_in == CH_LBRACE) || (byte_in == CH_LPAREN)
                   || (byte_in == CH_LBRACKET);
        is_close    = (byte_in == CH_RBRACE) || (byte_in == CH_RPAREN)
                   || (byte_in == CH_RBRACKET);

        priority if (sel_brace)
            sel_depth = cur.brace;
        else if (sel_paren)
            sel_depth = cur.paren;
        else
            sel_depth = cur.bracket;

        nxt       = cur;
        new_depth = sel_depth;
        latched   = 1'b0;

        if (enable && (cur.lat_status == ST_VALID))
        begin
            if (byte_in == CH_NEWLINE)
            begin
                if (cur.line == '0)
                    nxt.lat_status = ST_OVF;
                else
                begin
                    nxt.line   = (cur.line == '1) ? '0 : cur.line + LINE_W'(1);
                    nxt.column = COLUMN_W'(1);
                end
            end
            else if ((cur.line == '0) || (cur.column == '0))
                nxt.lat_status = ST_OVF;
            else
            begin
                if (is_open)
                begin
                    if (sel_depth == '1)
                    begin
                        nxt.lat_status = ST_OVF;
                        latched        = 1'b1;
                    end
                    else
                        new_depth = sel_depth + DEPTH_W'(1);
                end
                else if (is_close)
                begin
                    if (sel_depth == '0)
                    begin
                        nxt.lat_status = ST_CLOSE;
                        nxt.lat_line   = cur.line;
                        nxt.lat_column = cur.column;
                        latched        = 1'b1;
                    end
                    else
                        new_depth = sel_depth - DEPTH_W'(1);
                end

                if (sel_brace)
                    nxt.brace = new_depth;
                if (sel_paren)
                    nxt.paren = new_depth;
                if (sel_bracket)
                    nxt.bracket = new_depth;

                if (!latched)
                    nxt.column = (cur.column == '1) ? '0 : cur.column + COLUMN_W'(1);
            end
        end

        res = '0;
        if (enable)
        begin
            if (nxt.lat_status != ST_VALID)
                res.status = nxt.lat_status;
            else if ((nxt.brace != '0) || (nxt.paren != '0) || (nxt.bracket != '0))
                res.status = ST_OPEN;
            else
                res.status = ST_VALID;

            if (nxt.lat_status == ST_CLOSE)
            begin
                res.error_line   = LINE_FIELD_W'(nxt.lat_line);
                res.error_column = COLUMN_FIELD_W'(nxt.lat_column);
            end
            res.braces_left   = COUNT_FIELD_W'(nxt.brace);
            res.parens_left   = COUNT_FIELD_W'(nxt.paren);
            res.brackets_left = COUNT_FIELD_W'(nxt.bracket);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/delimiter_balance_checker.sv =====
// Path: a last beat waits in the input register, then its result is registered in the output register.
// Throughput: one beat per cycle; a last beat waits only while an earlier
//   result sits unaccepted in the output register.
// Reset (rst_n low, asynchronous): counters clear, line and column go to 1,
//   status to valid, the enable register to 1, both pipeline registers empty.
`default_nettype none

module delimiter_balance_checker import dbc_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write,
    input  wire logic                      check_enable,
    input  wire logic                      in_valid,
    output      logic                      in_ready,
    input  wire logic [7:0]                text_byte,
    input  wire logic                      last_byte,
    output      logic                      out_valid,
    input  wire logic                      out_ready,
    output      logic [1:0]                status,
    output      logic [LINE_FIELD_W-1:0]   error_line,
    output      logic [COLUMN_FIELD_W-1:0] error_column,
    output      logic [COUNT_FIELD_W-1:0]  open_braces_left,
    output      logic [COUNT_FIELD_W-1:0]  open_parens_left,
    output      logic [COUNT_FIELD_W-1:0]  open_brackets_left
);

    logic        enable_reg;
    logic        ib_valid_reg;
    logic        ib_valid_next;
    logic [7:0]  ib_byte_reg;
    logic        ib_last_reg;
    scan_state_t state_reg;
    scan_state_t state_next;
    scan_state_t step_state;
    result_t     step_res;
    logic        res_valid_reg;
    logic        res_valid_next;
    result_t     res_reg;
    logic        consume;
    logic        in_fire;

    dbc_step u_step (
        .enable  (enable_reg),
        .byte_in (ib_byte_reg),
        .cur     (state_reg),
        .nxt     (step_state),
        .res     (step_res)
    );

    always_comb
    begin
        consume  = ib_valid_reg && (!ib_last_reg || !res_valid_reg || out_ready);
        in_ready = !ib_valid_reg || consume;
        in_fire  = in_valid && in_ready;

        ib_valid_next = in_fire ? 1'b1 : (consume ? 1'b0 : ib_valid_reg);

        if (consume)
            state_next = ib_last_reg ? STATE_CLEAR : step_state;
        else
            state_next = state_reg;

        if (consume && ib_last_reg)
            res_valid_next = 1'b1;
        else if (out_ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b1;
            ib_valid_reg  <= 1'b0;
            state_reg     <= STATE_CLEAR;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                enable_reg <= check_enable;
            ib_valid_reg  <= ib_valid_next;
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ib_byte_reg <= text_byte;
            ib_last_reg <= last_byte;
        end
        if (consume && ib_last_reg)
            res_reg <= step_res;
    end

    assign out_valid          = res_valid_reg;
    assign status             = res_reg.status;
    assign error_line         = res_reg.error_line;
    assign error_column       = res_reg.error_column;
    assign open_braces_left   = res_reg.braces_left;
    assign open_parens_left   = res_reg.parens_left;
    assign open_brackets_left = res_reg.brackets_left;

endmodule

`default_nettype wire

// ===== rtl/core/dbc_checker.sv =====
`default_nettype none

module dbc_checker import dbc_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      cfg_write,
    input wire logic                      check_enable,
    input wire logic                      in_valid,
    input wire logic                      in_ready,
    input wire logic [7:0]                text_byte,
    input wire logic                      last_byte,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic [1:0]                status,
    input wire logic [LINE_FIELD_W-1:0]   error_line,
    input wire logic [COLUMN_FIELD_W-1:0] error_column,
    input wire logic [COUNT_FIELD_W-1:0]  open_braces_left,
    input wire logic [COUNT_FIELD_W-1:0]  open_parens_left,
    input wire logic [COUNT_FIELD_W-1:0]  open_brackets_left
);

    // stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(error_line) && $stable(error_column)
            && $stable(open_braces_left) && $stable(open_parens_left)
            && $stable(open_brackets_left))
        else $error("result beat changed while stalled");

    // error position only for an unmatched closing delimiter
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_CLOSE) |-> (error_line == '0) && (error_column == '0))
        else $error("error position set without unmatched closing");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_CLOSE) |-> (error_line != '0) && (error_column != '0))
        else $error("unmatched closing reported at position zero");

    // a valid text leaves nothing open
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_VALID) |-> (open_braces_left == '0)
            && (open_parens_left == '0) && (open_brackets_left == '0))
        else $error("valid status with open delimiters left");

endmodule

bind delimiter_balance_checker dbc_checker u_dbc_checker (.*);

`default_nettype wire

// ===== sim/delimiter_balance_checker_test.sv =====
`timescale 1ns / 1ps

module delimiter_balance_checker_test;
    import dbc_pkg::*;

    localparam logic [DEPTH_W-1:0]  DEPTH_MAX  = '1;
    localparam logic [LINE_W-1:0]   LINE_MAX   = '1;
    localparam logic [COLUMN_W-1:0] COLUMN_MAX = '1;

    localparam int KIND_BRACE   = 0;
    localparam int KIND_PAREN   = 1;
    localparam int KIND_BRACKET = 2;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write = 1'b0;
    logic                      check_enable = 1'b1;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [7:0]                text_byte = 8'h00;
    logic                      last_byte = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [1:0]                status;
    logic [LINE_FIELD_W-1:0]   error_line;
    logic [COLUMN_FIELD_W-1:0] error_column;
    logic [COUNT_FIELD_W-1:0]  open_braces_left;
    logic [COUNT_FIELD_W-1:0]  open_parens_left;
    logic [COUNT_FIELD_W-1:0]  open_brackets_left;

    // scanner state mirrored on the testbench side
    logic [DEPTH_W-1:0]  depth_lvl [3];
    logic [LINE_W-1:0]   line_pos;
    logic [COLUMN_W-1:0] col_pos;
    status_t             held_status;
    logic [LINE_W-1:0]   held_line;
    logic [COLUMN_W-1:0] held_col;
    logic                checking_on = 1'b1;

    result_t    pending_reports [$];
    logic [7:0] text_buf [$];

    int  sender_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_left = 0;
    int  beats_sent = 0;
    int  reports_checked = 0;
    bit  failed = 1'b0;

    delimiter_balance_checker dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .check_enable       (check_enable),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .text_byte          (text_byte),
        .last_byte          (last_byte),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .status             (status),
        .error_line         (error_line),
        .error_column       (error_column),
        .open_braces_left   (open_braces_left),
        .open_parens_left   (open_parens_left),
        .open_brackets_left (open_brackets_left)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [7:0] opener(input int kind);
        case (kind)
            KIND_BRACE: return CH_LBRACE;
            KIND_PAREN: return CH_LPAREN;
            default:    return CH_LBRACKET;
        endcase
    endfunction

    function automatic logic [7:0] closer(input int kind);
        case (kind)
            KIND_BRACE: return CH_RBRACE;
            KIND_PAREN: return CH_RPAREN;
            default:    return CH_RBRACKET;
        endcase
    endfunction

    function automatic void clear_scan();
        for (int i = 0; i < 3; i++)
        begin
            depth_lvl[i] = '0;
        end
        line_pos    = LINE_W'(1);
        col_pos     = COLUMN_W'(1);
        held_status = ST_VALID;
        held_line   = '0;
        held_col    = '0;
    endfunction

    function automatic void scan_char(input logic [7:0] c);
        int kind;
        bit opening;
        if (held_status != ST_VALID)
            return;
        if (c == CH_NEWLINE)
        begin
            if (line_pos == 0)
                held_status = ST_OVF;
            else
            begin
                line_pos = (line_pos == LINE_MAX) ? '0 : line_pos + LINE_W'(1);
                col_pos  = COLUMN_W'(1);
            end
            return;
        end
        // no valid position any more
        if (line_pos == 0 || col_pos == 0)
        begin
            held_status = ST_OVF;
            return;
        end
        kind = -1;
        opening = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (c == opener(i))
            begin
                kind = i;
                opening = 1'b1;
            end
            if (c == closer(i))
                kind = i;
        end
        if (kind >= 0)
        begin
            if (opening)
            begin
                if (depth_lvl[kind] == DEPTH_MAX)
                    held_status = ST_OVF;
                else
                    depth_lvl[kind] = depth_lvl[kind] + DEPTH_W'(1);
            end
            else if (depth_lvl[kind] == 0)
            begin
                held_status = ST_CLOSE;
                held_line   = line_pos;
                held_col    = col_pos;
            end
            else
                depth_lvl[kind] = depth_lvl[kind] - DEPTH_W'(1);
        end
        if (held_status == ST_VALID)
            col_pos = (col_pos == COLUMN_MAX) ? '0 : col_pos + COLUMN_W'(1);
    endfunction

    function automatic void predict_beat(input logic [7:0] c, input logic last);
        result_t r;
        if (checking_on)
            scan_char(c);
        if (!last)
            return;
        r = '0;
        if (checking_on)
        begin
            r.status = held_status;
            if (r.status == ST_VALID && (depth_lvl[KIND_BRACE] != 0 ||
                depth_lvl[KIND_PAREN] != 0 || depth_lvl[KIND_BRACKET] != 0))
                r.status = ST_OPEN;
            if (r.status == ST_CLOSE)
            begin
                r.error_line   = held_line;
                r.error_column = held_col;
            end
            r.braces_left   = depth_lvl[KIND_BRACE];
            r.parens_left   = depth_lvl[KIND_PAREN];
            r.brackets_left = depth_lvl[KIND_BRACKET];
        end
        pending_reports.push_back(r);
        clear_scan();
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failed = 1'b1;
        end
    endfunction

    always @(posedge clk)
    begin : check_reports
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("report with none pending: status %0d", status);
                failed = 1'b1;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("status", want.status, status);
                check_field("error_line", want.error_line, error_line);
                check_field("error_column", want.error_column, error_column);
                check_field("open_braces_left", want.braces_left, open_braces_left);
                check_field("open_parens_left", want.parens_left, open_parens_left);
                check_field("open_brackets_left", want.brackets_left, open_brackets_left);
                reports_checked++;
            end
        end
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_beat(input logic [7:0] c, input logic last);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid  <= 1'b1;
        text_byte <= c;
        last_byte <= last;
        do
            @(posedge clk);
        while (!in_ready);
        predict_beat(c, last);
        beats_sent++;
    endtask

    task automatic send_text(input bit ends);
        for (int i = 0; i < text_buf.size(); i++)
        begin
            send_beat(text_buf[i], ends && (i == text_buf.size() - 1));
        end
    endtask

    task automatic load_string(input string s);
        text_buf.delete();
        for (int i = 0; i < s.len(); i++)
        begin
            text_buf.push_back(s[i]);
        end
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_check_enable(input logic value);
        wait_drain();
        cfg_write    <= 1'b1;
        check_enable <= value;
        @(posedge clk);
        cfg_write    <= 1'b0;
        checking_on = value;
    endtask

    // mostly nested text with random filler, some left open or over-closed, some noise
    task automatic build_random_text();
        int open_kinds [$];
        int mode;
        int len;
        int pick;
        int kind;
        text_buf.delete();
        mode = $urandom_range(99);
        len = $urandom_range(1, 30);
        if (mode >= 85)
        begin
            repeat (len) text_buf.push_back(8'($urandom_range(255)));
            return;
        end
        repeat (len)
        begin
            pick = $urandom_range(9);
            if (pick < 3)
            begin
                kind = $urandom_range(2);
                open_kinds.push_back(kind);
                text_buf.push_back(opener(kind));
            end
            else if (pick < 6 && open_kinds.size() > 0)
                text_buf.push_back(closer(open_kinds.pop_back()));
            else if (pick == 6)
                text_buf.push_back(CH_NEWLINE);
            else
                text_buf.push_back(8'($urandom_range(255)));
        end
        if (mode < 70)
        begin
            while (open_kinds.size() > 0)
                text_buf.push_back(closer(open_kinds.pop_back()));
        end
        else if ($urandom_range(1) == 1)
            text_buf.push_back(closer($urandom_range(2)));
    endtask

    task automatic test_directed_basics();
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        load_string("{([])}");
        send_text(1);
        load_string(")");
        send_text(1);
        load_string("a\nb}");
        send_text(1);
        load_string("((");
        send_text(1);
        load_string("{]");
        send_text(1);
        load_string(")(");
        send_text(1);
        load_string("\n");
        send_text(1);
        load_string("[x\n\n  ]]");
        send_text(1);
        text_buf.delete();
        text_buf.push_back(8'h00);
        text_buf.push_back(8'hFF);
        send_text(1);
    endtask

    task automatic test_check_disabled();
        write_check_enable(1'b0);
        load_string("}}}");
        send_text(1);
        load_string("((");
        send_text(1);
        write_check_enable(1'b1);
    endtask

    task automatic test_mid_text_pause();
        load_string("()");
        send_text(1);
        load_string("{(a\n");
        send_text(0);
        wait_drain();
        load_string("b)}");
        send_text(1);
        wait_drain();
    endtask

    task automatic test_output_holdoff();
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drain();
        hold_left = 300;
        repeat (40)
        begin
            load_string("[a]");
            send_text(1);
        end
        wait_drain();
    endtask

    task automatic run_random_phase(input int n_beats, input int send_pct,
                                    input int recv_pct, input logic enable);
        int start;
        if (enable != checking_on)
            write_check_enable(enable);
        sender_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        start = beats_sent;
        while (beats_sent - start < n_beats)
        begin
            build_random_text();
            send_text(1);
        end
    endtask

    initial
    begin
        clear_scan();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_basics();
        test_check_disabled();
        test_mid_text_pause();
        test_output_holdoff();
        run_random_phase(500, 0, 0, 1'b1);
        run_random_phase(400, 55, 0, 1'b1);
        run_random_phase(400, 0, 55, 1'b1);
        run_random_phase(200, 20, 20, 1'b0);
        run_random_phase(300, 20, 20, 1'b1);
        wait_drain();
        $display("Checked %0d reports over %0d beats: balanced, unmatched, unclosed",
                 reports_checked, beats_sent);
        $display("and disabled texts, with input gaps, output stalls and a long hold-off.");
        if (!failed)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
